[hw/rtl/tpw2d_pkg.sv]
// Shared constants and types for the triclinic periodic wrap core.
package tpw2d_pkg;

   // Fixed-point formats: coordinates Q.COORD_FRAC_BITS, reciprocals Q.SCALE_FRAC_BITS.
   localparam int COORD_FRAC_BITS = 16;
   localparam int SCALE_FRAC_BITS = 24;

   localparam int COORD_W    = 32;
   localparam int LEN_W      = 31;
   localparam int INV_W      = 32;
   localparam int REG_COUNT  = 7;
   localparam int CSR_IDX_W  = $clog2(REG_COUNT);
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOX_X_LOW = 3'd0,
      REG_BOX_Y_LOW = 3'd1,
      REG_BOX_LEN_X = 3'd2,
      REG_BOX_LEN_Y = 3'd3,
      REG_TILT_XY   = 3'd4,
      REG_INV_LEN_X = 3'd5,
      REG_INV_LEN_Y = 3'd6
   } csr_reg_type;

   // Reset values: unit box at the origin with no shear.
   localparam logic signed [COORD_W-1:0] RST_BOX_X_LOW = '0;
   localparam logic signed [COORD_W-1:0] RST_BOX_Y_LOW = '0;
   localparam logic [LEN_W-1:0]          RST_BOX_LEN   = LEN_W'(1) << COORD_FRAC_BITS;
   localparam logic signed [COORD_W-1:0] RST_TILT_XY   = '0;
   localparam logic [INV_W-1:0]          RST_INV_LEN   = INV_W'(1) << SCALE_FRAC_BITS;

endpackage

[hw/rtl/triclinic_periodic_wrap_2d_core.sv]
// Top level of the triclinic periodic wrap core: a nine-stage point pipeline.
//
// Usage: each word on the req_ channel is one 2D point in signed Q16.16; the
// core folds it into the sheared periodic box held in the csr_ registers and
// returns the wrapped point as one word on the rsp_ channel, tlast copied.
// The user must write the box registers (csr_we/csr_index/csr_wdata) only while
// no point is in flight, unenforced here; writes past the last register are ignored.
// A word passes through the nine register stages in order, stage 1 to stage 9,
// and its result is held on rsp_ from stage 9. Throughput is one point per
// cycle while rsp_tready stays high, since all nine register stages then
// advance together; a low rsp_tready can hold the flow.
// Each stage advances when it is empty or the stage after it advances, so
// when rsp_tready is low, empty stages still fill and req_tready drops only
// once every stage holds a word. Nothing is lost or repeated under a stall.
// Reset (synchronous, active high) empties the pipeline and loads a unit box
// at the origin with zero tilt and unit reciprocals.
// Outputs that fall outside 32 bits are saturated to the signed limits.
module triclinic_periodic_wrap_2d_core #(
   parameter int COORD_FRAC_BITS = tpw2d_pkg::COORD_FRAC_BITS,
   parameter int SCALE_FRAC_BITS = tpw2d_pkg::SCALE_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [63:0]                            req_tdata,   // x_in[31:0], y_in[63:32]
   input  logic                                   req_tlast,   // last_point
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [63:0]                            rsp_tdata,   // x_out[31:0], y_out[63:32]
   output logic                                   rsp_tlast,   // last_out
   input  logic                                   csr_we,
   input  logic [tpw2d_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpw2d_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CW    = tpw2d_pkg::COORD_W;
   localparam int LW    = tpw2d_pkg::LEN_W;
   localparam int IW    = tpw2d_pkg::INV_W;
   localparam int C     = COORD_FRAC_BITS;
   localparam int S     = SCALE_FRAC_BITS;
   localparam int DW    = CW + 1;              // origin-relative coordinate
   localparam int S1_W  = 2 * CW + 1 - C;      // exact fractional y coordinate
   localparam int S1_LO = (S1_W + 1) / 2;
   localparam int S1_HI = S1_W - S1_LO;
   localparam int W     = C + S;               // bits of w that reach frac(s0)
   localparam int WL    = W / 2;
   localparam int WH    = W - WL;
   localparam int PW    = (CW + S1_W > S + W) ? CW + S1_W : S + W;
   localparam int NS    = 9;

   // Configuration registers.
   logic signed [CW-1:0] box_x_low_ff, box_y_low_ff, tilt_xy_ff;
   logic [LW-1:0]        box_len_x_ff, box_len_y_ff;
   logic [IW-1:0]        inv_len_x_ff, inv_len_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_low_ff <= tpw2d_pkg::RST_BOX_X_LOW;
         box_y_low_ff <= tpw2d_pkg::RST_BOX_Y_LOW;
         box_len_x_ff <= tpw2d_pkg::RST_BOX_LEN;
         box_len_y_ff <= tpw2d_pkg::RST_BOX_LEN;
         tilt_xy_ff   <= tpw2d_pkg::RST_TILT_XY;
         inv_len_x_ff <= tpw2d_pkg::RST_INV_LEN;
         inv_len_y_ff <= tpw2d_pkg::RST_INV_LEN;
      end else if (csr_we) begin
         unique case (tpw2d_pkg::csr_reg_type'(csr_index))
            tpw2d_pkg::REG_BOX_X_LOW: box_x_low_ff <= csr_wdata[CW-1:0];
            tpw2d_pkg::REG_BOX_Y_LOW: box_y_low_ff <= csr_wdata[CW-1:0];
            tpw2d_pkg::REG_BOX_LEN_X: box_len_x_ff <= csr_wdata[LW-1:0];
            tpw2d_pkg::REG_BOX_LEN_Y: box_len_y_ff <= csr_wdata[LW-1:0];
            tpw2d_pkg::REG_TILT_XY:   tilt_xy_ff   <= csr_wdata[CW-1:0];
            tpw2d_pkg::REG_INV_LEN_X: inv_len_x_ff <= csr_wdata[IW-1:0];
            tpw2d_pkg::REG_INV_LEN_Y: inv_len_y_ff <= csr_wdata[IW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control: valid bits per stage, each stage loads when enabled.
   logic [NS:1]   valid_ff;
   logic [NS:1]   valid_in;
   logic [NS+1:1] en;

   always_comb begin
      en[NS+1] = rsp_tready;
      for (int k = NS; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = req_tvalid;
      for (int k = 2; k <= NS; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = valid_ff[NS];

   // Last flag rides along every stage.
   logic [NS:1] last_ff;
   always_ff @(posedge clock) begin
      if (en[1]) begin
         last_ff[1] <= req_tlast;
      end
      for (int k = 2; k <= NS; k++) begin
         if (en[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // Stage 1: subtract the box origin.
   logic signed [DW-1:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   assign dx1_in = DW'($signed(req_tdata[CW-1:0])) - DW'(box_x_low_ff);
   assign dy1_in = DW'($signed(req_tdata[2*CW-1:CW])) - DW'(box_y_low_ff);

   // Stage 2: s1 = floor(dy * inv_len_y / 2^C), exact.
   logic signed [DW+IW:0]   s1_prod;
   logic signed [S1_W-1:0]  s1_2_ff, s1_2_in;
   logic signed [DW-1:0]    dx2_ff;
   assign s1_prod = dy1_ff * $signed({1'b0, inv_len_y_ff});
   assign s1_2_in = s1_prod[C +: S1_W];

   // Stage 3: shear partial products, plus the two products that use frac(s1).
   logic [S-1:0]                 f1;
   logic signed [CW+S1_LO:0]     ptlo3_ff, ptlo3_in;
   logic signed [CW+S1_HI-1:0]   pthi3_ff, pthi3_in;
   logic signed [CW+S:0]         xb_prod;
   logic [LW+S-1:0]              ya_prod;
   logic signed [CW-1:0]         xb3_ff, xb3_in;
   logic [LW-1:0]                ya3_ff, ya3_in;
   logic signed [DW-1:0]         dx3_ff;
   assign f1       = s1_2_ff[S-1:0];
   assign ptlo3_in = tilt_xy_ff * $signed({1'b0, s1_2_ff[S1_LO-1:0]});
   assign pthi3_in = tilt_xy_ff * $signed(s1_2_ff[S1_W-1:S1_LO]);
   assign xb_prod  = tilt_xy_ff * $signed({1'b0, f1});
   assign xb3_in   = xb_prod[S +: CW];
   assign ya_prod  = box_len_y_ff * f1;
   assign ya3_in   = ya_prod[S +: LW];

   // Stage 4: combine the shear halves; only the bits reaching frac(s0) are kept.
   logic signed [PW-1:0]  shear_sum;
   logic [W-1:0]          shear4_ff, shear4_in;
   logic signed [DW-1:0]  dx4_ff;
   logic signed [CW-1:0]  xb4_ff;
   logic [LW-1:0]         ya4_ff;
   assign shear_sum = PW'(ptlo3_ff) + (PW'(pthi3_ff) <<< S1_LO);
   assign shear4_in = shear_sum[S +: W];

   // Stage 5: w = dx - shear, modulo 2^W.
   logic [W-1:0]          w5_ff, w5_in;
   logic signed [CW-1:0]  xb5_ff;
   logic [LW-1:0]         ya5_ff;
   assign w5_in = W'(dx4_ff) - shear4_ff;

   // Stage 6: w * inv_len_x as two partial products, modulo 2^W.
   logic [WL+IW-1:0]      ml6_ff, ml6_in;
   logic [2*WH-1:0]       mh_prod;
   logic [WH-1:0]         mh6_ff, mh6_in;
   logic signed [CW-1:0]  xb6_ff;
   logic [LW-1:0]         ya6_ff;
   assign ml6_in  = w5_ff[WL-1:0] * inv_len_x_ff;
   assign mh_prod = w5_ff[W-1:WL] * inv_len_x_ff[WH-1:0];
   assign mh6_in  = mh_prod[WH-1:0];

   // Stage 7: frac(s0) from the summed partial products.
   logic [W-1:0]          m_sum;
   logic [S-1:0]          f0_7_ff, f0_7_in;
   logic signed [CW-1:0]  xb7_ff;
   logic [LW-1:0]         ya7_ff;
   assign m_sum   = ml6_ff[W-1:0] + {mh6_ff, {WL{1'b0}}};
   assign f0_7_in = m_sum[W-1:C];

   // Stage 8: lx * frac(s0).
   logic [LW+S-1:0]       xa_prod;
   logic [LW-1:0]         xa8_ff, xa8_in;
   logic signed [CW-1:0]  xb8_ff;
   logic [LW-1:0]         ya8_ff;
   assign xa_prod = box_len_x_ff * f0_7_ff;
   assign xa8_in  = xa_prod[S +: LW];

   // Stage 9: add the origin back and saturate to 32 bits.
   logic signed [CW+1:0]  x_sum;
   logic signed [CW:0]    y_sum;
   logic [CW-1:0]         x9_ff, x9_in, y9_ff, y9_in;
   assign x_sum = $signed({3'b000, xa8_ff}) + (CW+2)'(xb8_ff) + (CW+2)'(box_x_low_ff);
   assign y_sum = $signed({2'b00, ya8_ff}) + (CW+1)'(box_y_low_ff);

   always_comb begin
      if (x_sum[CW+1:CW-1] == 3'b000 || x_sum[CW+1:CW-1] == 3'b111) begin
         x9_in = x_sum[CW-1:0];
      end else begin
         x9_in = {x_sum[CW+1], {(CW-1){!x_sum[CW+1]}}};
      end
      if (y_sum[CW] == y_sum[CW-1]) begin
         y9_in = y_sum[CW-1:0];
      end else begin
         y9_in = {y_sum[CW], {(CW-1){!y_sum[CW]}}};
      end
   end

   // Datapath registers; no reset needed.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
      end
      if (en[2]) begin
         s1_2_ff <= s1_2_in;
         dx2_ff  <= dx1_ff;
      end
      if (en[3]) begin
         ptlo3_ff <= ptlo3_in;
         pthi3_ff <= pthi3_in;
         xb3_ff   <= xb3_in;
         ya3_ff   <= ya3_in;
         dx3_ff   <= dx2_ff;
      end
      if (en[4]) begin
         shear4_ff <= shear4_in;
         dx4_ff    <= dx3_ff;
         xb4_ff    <= xb3_ff;
         ya4_ff    <= ya3_ff;
      end
      if (en[5]) begin
         w5_ff  <= w5_in;
         xb5_ff <= xb4_ff;
         ya5_ff <= ya4_ff;
      end
      if (en[6]) begin
         ml6_ff <= ml6_in;
         mh6_ff <= mh6_in;
         xb6_ff <= xb5_ff;
         ya6_ff <= ya5_ff;
      end
      if (en[7]) begin
         f0_7_ff <= f0_7_in;
         xb7_ff  <= xb6_ff;
         ya7_ff  <= ya6_ff;
      end
      if (en[8]) begin
         xa8_ff <= xa8_in;
         xb8_ff <= xb7_ff;
         ya8_ff <= ya7_ff;
      end
      if (en[9]) begin
         x9_ff <= x9_in;
         y9_ff <= y9_in;
      end
   end

   assign rsp_tdata = {y9_ff, x9_ff};
   assign rsp_tlast = last_ff[NS];

   // A full pipeline with a stalled receiver must stop taking words.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("input taken while every stage is full and output stalled");

   // An accepted word always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[1])
      else $error("accepted word missing from first stage");

   // A held middle stage keeps its word.
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && !en[5] |=> valid_ff[5])
      else $error("stalled word dropped in middle stage");

endmodule
